// ===== sv/bc_texture_block_decoder_macros.svh =====
// assertion macros shared by the decoder checks
`ifndef BC_TEXTURE_BLOCK_DECODER_MACROS_SVH
`define BC_TEXTURE_BLOCK_DECODER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define BCTD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bctd check failed");

// next-cycle implication, sampled on clk, off during reset
`define BCTD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bctd check failed");

`endif

// ===== sv/bctd_pkg.sv =====
// shared types, constants and helper functions of the block decoder
package bctd_pkg;

	typedef enum logic [1:0] {
		FMT_BC1 = 2'd0,
		FMT_BC3 = 2'd1,
		FMT_BC4 = 2'd2,
		FMT_BC5 = 2'd3
	} fmt_t;

	localparam logic [13:0] RECIP7 = 14'd9363;
	localparam logic [13:0] RECIP5 = 14'd13108;
	localparam logic [14:0] RECIP3 = 15'd21846;
	localparam logic [7:0] CH_MAX = 8'd255;
	localparam logic [3:0] LAST_PIX = 4'd15;
	localparam logic [5:0] CIDX_OFS = 6'd16;

	typedef struct packed {
		fmt_t fmt;
		logic punch;
		logic [7:0][7:0] apal;
		logic [7:0][7:0] gpal;
		logic [3:0][2:0][7:0] cpal;
		logic [47:0] lo_idx;
		logic [47:0] hi_idx;
	} bank_t;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
		logic [7:0] a;
	} pixel_t;

	function automatic logic [7:0] widen5(input logic [4:0] v);
		return {v, v[4:2]};
	endfunction

	function automatic logic [7:0] widen6(input logic [5:0] v);
		return {v, v[5:4]};
	endfunction

	// floor(x / 3) for x up to 765
	function automatic logic [7:0] div3(input logic [9:0] x);
		logic [24:0] p;
		p = 25'(x) * 25'(RECIP3);
		return p[23:16];
	endfunction

endpackage

// ===== sv/bctd_alpha_lane.sv =====
// one entry of an eight-entry alpha-style palette
module bctd_alpha_lane (
	input  logic [7:0] v0,
	input  logic [7:0] v1,
	input  logic [2:0] entry,
	output logic [7:0] value
);
	import bctd_pkg::*;

	logic        gt;
	logic [2:0]  wi;
	logic [2:0]  w0;
	logic [10:0] sum;
	logic [13:0] recip;
	logic [24:0] prod;

	always_comb begin
		gt    = v0 > v1;
		wi    = entry - 3'd1;
		w0    = gt ? (3'd7 - wi) : (3'd5 - wi);
		sum   = 11'(w0) * 11'(v0) + 11'(wi) * 11'(v1);
		recip = gt ? RECIP7 : RECIP5;
		prod  = 25'(sum) * 25'(recip);
		priority if (entry == 3'd0) begin
			value = v0;
		end else if (entry == 3'd1) begin
			value = v1;
		end else if (gt || entry <= 3'd5) begin
			value = prod[23:16];
		end else if (entry == 3'd6) begin
			value = 8'd0;
		end else begin
			value = CH_MAX;
		end
	end

endmodule

// ===== sv/bctd_colour_lane.sv =====
// interpolated entries of one colour channel
module bctd_colour_lane (
	input  logic [7:0] e0,
	input  logic [7:0] e1,
	input  logic       four,
	output logic [7:0] p2,
	output logic [7:0] p3
);
	import bctd_pkg::*;

	logic [9:0] s2;
	logic [9:0] s3;
	logic [8:0] avg_sum;

	always_comb begin
		s2      = {1'b0, e0, 1'b0} + {2'b0, e1};
		s3      = {2'b0, e0} + {1'b0, e1, 1'b0};
		avg_sum = {1'b0, e0} + {1'b0, e1};
		p2      = four ? div3(s2) : avg_sum[8:1];
		p3      = four ? div3(s3) : 8'd0;
	end

endmodule

// ===== sv/bctd_pixel_mux.sv =====
// merges the lane palettes into the pixel selected by the counter
module bctd_pixel_mux (
	input  bctd_pkg::bank_t  bank,
	input  logic [3:0]       idx,
	output bctd_pkg::pixel_t pix
);
	import bctd_pkg::*;

	logic [5:0]  abase;
	logic [5:0]  cbase;
	logic [2:0]  a_lo;
	logic [2:0]  a_hi;
	logic [47:0] cword;
	logic [1:0]  cs;

	always_comb begin
		abase = {1'b0, idx, 1'b0} + {2'b0, idx};
		cbase = {1'b0, idx, 1'b0} + CIDX_OFS;
		a_lo  = bank.lo_idx[abase +: 3];
		a_hi  = bank.hi_idx[abase +: 3];
		cword = (bank.fmt == FMT_BC1) ? bank.lo_idx : bank.hi_idx;
		cs    = cword[cbase +: 2];
		unique case (bank.fmt)
			FMT_BC1: begin
				pix.r = bank.cpal[cs][0];
				pix.g = bank.cpal[cs][1];
				pix.b = bank.cpal[cs][2];
				pix.a = (bank.punch && cs == 2'd3) ? 8'd0 : CH_MAX;
			end
			FMT_BC3: begin
				pix.r = bank.cpal[cs][0];
				pix.g = bank.cpal[cs][1];
				pix.b = bank.cpal[cs][2];
				pix.a = bank.apal[a_lo];
			end
			FMT_BC4: begin
				pix.r = bank.apal[a_lo];
				pix.g = bank.apal[a_lo];
				pix.b = bank.apal[a_lo];
				pix.a = CH_MAX;
			end
			FMT_BC5: begin
				pix.r = bank.apal[a_lo];
				pix.g = bank.gpal[a_hi];
				pix.b = 8'd0;
				pix.a = CH_MAX;
			end
		endcase
	end

endmodule

// ===== sv/bc_texture_block_decoder.sv =====
// bc1/bc3/bc4/bc5 block decoder top level: palette lanes, palette bank, pixel output register
// path: input register, palette bank, then pixel output register for the block's pixels
// throughput: sixteen pixels per block, one per cycle while out_ready does not stall them;
// the block rate is set by the single pixel output port draining the palette bank
// reset: arst_n clears the format register to bc1 and empties every pipeline stage
module bc_texture_block_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] block_low,
	input  logic [63:0] block_high,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  alpha,
	output logic [3:0]  pixel_index,
	output logic        last_pixel
);
	import bctd_pkg::*;

	fmt_t        fmt_q;
	logic        valid_s1;
	logic [63:0] low_s1;
	logic [63:0] high_s1;
	logic        valid_s2;
	bank_t       bank_s2;
	bank_t       bank_next;
	logic [3:0]  cnt_q;
	logic        out_valid_q;
	pixel_t      pix_q;
	pixel_t      pix_next;
	logic [3:0]  idx_q;
	logic        last_q;

	logic        out_load;
	logic        bank_free;
	logic        ld_s2;

	logic [31:0]      cw;
	logic [15:0]      c0;
	logic [15:0]      c1;
	logic             four;
	logic [2:0][7:0]  e0;
	logic [2:0][7:0]  e1;
	logic [2:0][7:0]  p2;
	logic [2:0][7:0]  p3;
	logic [7:0][7:0]  apal;
	logic [7:0][7:0]  gpal;

	assign cfg_ready = 1'b1;
	assign out_load  = valid_s2 && (!out_valid_q || out_ready);
	assign bank_free = !valid_s2 || (out_load && cnt_q == LAST_PIX);
	assign ld_s2     = valid_s1 && bank_free;
	assign in_ready  = !valid_s1 || ld_s2;

	always_comb begin
		cw    = (fmt_q == FMT_BC1) ? low_s1[31:0] : high_s1[31:0];
		c0    = cw[15:0];
		c1    = cw[31:16];
		four  = (fmt_q != FMT_BC1) || (c0 > c1);
		e0[0] = widen5(c0[15:11]);
		e0[1] = widen6(c0[10:5]);
		e0[2] = widen5(c0[4:0]);
		e1[0] = widen5(c1[15:11]);
		e1[1] = widen6(c1[10:5]);
		e1[2] = widen5(c1[4:0]);
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_colour
		bctd_colour_lane u_lane (
			.e0   (e0[ch]),
			.e1   (e1[ch]),
			.four (four),
			.p2   (p2[ch]),
			.p3   (p3[ch])
		);
	end

	for (genvar k = 0; k < 8; k++) begin : g_alpha
		bctd_alpha_lane u_lo (
			.v0    (low_s1[7:0]),
			.v1    (low_s1[15:8]),
			.entry (3'(k)),
			.value (apal[k])
		);
		bctd_alpha_lane u_hi (
			.v0    (high_s1[7:0]),
			.v1    (high_s1[15:8]),
			.entry (3'(k)),
			.value (gpal[k])
		);
	end

	always_comb begin
		bank_next.fmt    = fmt_q;
		bank_next.punch  = !four;
		bank_next.apal   = apal;
		bank_next.gpal   = gpal;
		bank_next.cpal[0] = e0;
		bank_next.cpal[1] = e1;
		bank_next.cpal[2] = p2;
		bank_next.cpal[3] = p3;
		bank_next.lo_idx = low_s1[63:16];
		bank_next.hi_idx = high_s1[63:16];
	end

	bctd_pixel_mux u_mux (
		.bank (bank_s2),
		.idx  (cnt_q),
		.pix  (pix_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q       <= FMT_BC1;
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			cnt_q       <= 4'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				fmt_q <= fmt_t'(cfg_data);
			end
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (bank_free) begin
				valid_s2 <= valid_s1;
			end
			if (out_load) begin
				cnt_q <= cnt_q + 4'd1;
			end
			if (!out_valid_q || out_ready) begin
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			low_s1  <= block_low;
			high_s1 <= block_high;
		end
		if (ld_s2) begin
			bank_s2 <= bank_next;
		end
		if (out_load) begin
			pix_q  <= pix_next;
			idx_q  <= cnt_q;
			last_q <= (cnt_q == LAST_PIX);
		end
	end

	assign out_valid   = out_valid_q;
	assign red         = pix_q.r;
	assign green       = pix_q.g;
	assign blue        = pix_q.b;
	assign alpha       = pix_q.a;
	assign pixel_index = idx_q;
	assign last_pixel  = last_q;

endmodule

// ===== sv/bctd_checker.sv =====
// port-level checks of the block decoder and their bind to the top level
`include "bc_texture_block_decoder_macros.svh"

module bctd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  red,
	input logic [7:0]  green,
	input logic [7:0]  blue,
	input logic [7:0]  alpha,
	input logic [3:0]  pixel_index,
	input logic        last_pixel
);

	logic        out_acc;
	logic [36:0] out_word;
	logic [3:0]  next_index;

	assign out_acc    = out_valid && out_ready;
	assign out_word   = {red, green, blue, alpha, pixel_index, last_pixel};
	assign next_index = pixel_index + 4'd1;

	// stalled result holds
	`BCTD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_word))

	// last marker tracks the pixel position
	`BCTD_ASSERT_NOW(a_last_idx, out_valid, last_pixel == (pixel_index == 4'd15))

	// pixels of a block come back to back in raster order
	`BCTD_ASSERT_NEXT(a_idx_step, out_acc && !last_pixel, out_valid && pixel_index == $past(next_index))

	// a new block starts at pixel zero
	`BCTD_ASSERT_NEXT(a_idx_wrap, out_acc && last_pixel, !out_valid || pixel_index == 4'd0)

endmodule

bind bc_texture_block_decoder bctd_checker u_bctd_checker (.*);
